/* design/assert_macros.svh */
// assertion macros shared by the modbus response checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check that is held off while reset is asserted
`define MRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define MRC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/mrc_pkg.sv */
// types, constants and crc function for the modbus response checker
`timescale 1ns / 1ps

package mrc_pkg;

    localparam int CNT_W               = 5;
    localparam int MAX_FRAME_BYTES_DEF = 16;

    localparam logic [15:0]      CRC_POLY    = 16'hA001;
    localparam logic [15:0]      CRC_INIT    = 16'hFFFF;
    localparam logic [CNT_W-1:0] GOOD_LENGTH = 5'd7;
    localparam logic [CNT_W-1:0] MIN_LENGTH  = 5'd2;
    localparam logic [CNT_W-1:0] READ_HI_IDX = 5'd3;
    localparam logic [CNT_W-1:0] READ_LO_IDX = 5'd4;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_LEN = 2'd1,
        STAT_CRC = 2'd2
    } status_t;

    // one byte into crc-16/modbus, eight shift steps unrolled
    function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* design/modbus_response_checker.sv */
// modbus rtu read-input-register response checker, top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   Input channel in_valid/in_stall carries one frame word per cycle:
//   rx_byte, frame_end (set on the last word of a frame) and register_index.
//   Output channel out_valid/out_stall carries one result word per frame:
//   status (ok, length not seven, crc mismatch), reading (bytes three and
//   four, big endian, zero unless ok) and reg_echo.
//   A word is accepted at a clock edge with valid high and stall low.
// Throughput and path:
//   one input word per cycle while in_stall is low; the result of a frame
//   is built from its last word through the input register, then the result register.
//   The crc update is one unrolled eight-step byte update between the two.
// Stalls:
//   a stalled result holds; words that do not end a frame keep flowing,
//   and a frame end waits in the input register until the result register
//   frees, which then stalls the input side.
// Reset:
//   rst_n is asynchronous, active low; it empties both registers and clears
//   the frame state (crc to all ones, count, trailer and reading to zero).
module modbus_response_checker
    import mrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    input  logic [7:0]  register_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] reading,
    output logic [7:0]  reg_echo
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

    // input register
    logic             in_vld_reg;
    logic             in_vld_next;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic [7:0]       in_idx_reg;

    // frame state
    logic [15:0]      crc_reg,     crc_next;
    logic [15:0]      trailer_reg, trailer_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [15:0]      hold_reg,    hold_next;

    // result register
    logic             out_vld_reg, out_vld_next;
    status_t          status_reg,  status_next;
    logic [15:0]      reading_reg, reading_next;
    logic [7:0]       echo_reg;

    logic             process;
    logic             in_take;
    logic [15:0]      crc_upd;
    logic [15:0]      trailer_upd;
    logic [15:0]      hold_upd;
    logic [CNT_W-1:0] count_upd;
    logic [15:0]      expected;

    // handshake: a frame end needs a free result register
    assign process  = in_vld_reg && (!in_last_reg || !out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !process;
    assign in_take  = in_valid && !in_stall;

    assign in_vld_next = in_take ? 1'b1 : (process ? 1'b0 : in_vld_reg);

    // one word through the crc, trailer, reading capture and counter
    always_comb
    begin
        crc_upd     = (count_reg >= MIN_LENGTH) ? crc_feed(crc_reg, trailer_reg[15:8])
                                                : crc_reg;
        trailer_upd = {trailer_reg[7:0], in_byte_reg};
        hold_upd    = hold_reg;
        if (count_reg == READ_HI_IDX)
        begin
            hold_upd[15:8] = in_byte_reg;
        end
        else if (count_reg == READ_LO_IDX)
        begin
            hold_upd[7:0] = in_byte_reg;
        end
        count_upd = (count_reg < CNT_MAX) ? count_reg + CNT_W'(1) : count_reg;
        expected  = {trailer_upd[7:0], trailer_upd[15:8]};
    end

    // next frame state, cleared after a frame end
    always_comb
    begin
        crc_next     = crc_reg;
        trailer_next = trailer_reg;
        count_next   = count_reg;
        hold_next    = hold_reg;
        if (process)
        begin
            if (in_last_reg)
            begin
                crc_next     = CRC_INIT;
                trailer_next = '0;
                count_next   = '0;
                hold_next    = '0;
            end
            else
            begin
                crc_next     = crc_upd;
                trailer_next = trailer_upd;
                count_next   = count_upd;
                hold_next    = hold_upd;
            end
        end
    end

    // result word, crc mismatch wins over length error
    always_comb
    begin
        priority if (count_upd < MIN_LENGTH || crc_upd != expected)
        begin
            status_next = STAT_CRC;
        end
        else if (count_upd != GOOD_LENGTH)
        begin
            status_next = STAT_LEN;
        end
        else
        begin
            status_next = STAT_OK;
        end
        reading_next = (status_next == STAT_OK) ? hold_upd : 16'h0000;
        out_vld_next = (process && in_last_reg) ? 1'b1 : (out_vld_reg && out_stall);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            crc_reg     <= CRC_INIT;
            trailer_reg <= '0;
            count_reg   <= '0;
            hold_reg    <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            crc_reg     <= crc_next;
            trailer_reg <= trailer_next;
            count_reg   <= count_next;
            hold_reg    <= hold_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
            in_last_reg <= frame_end;
            in_idx_reg  <= register_index;
        end
        if (process && in_last_reg)
        begin
            status_reg  <= status_next;
            reading_reg <= reading_next;
            echo_reg    <= in_idx_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign status    = status_reg;
    assign reading   = reading_reg;
    assign reg_echo  = echo_reg;

    // checks
    `MRC_ASSERT(a_count_sat, count_reg <= CNT_MAX, "byte count above frame limit")
    `MRC_ASSERT(a_reading_zero, (out_vld_reg && status_reg != STAT_OK) |-> reading_reg == 16'h0000, "reading not zero on error")
    `MRC_ASSERT(a_result_from_end, $rose(out_vld_reg) |-> $past(process && in_last_reg), "result without frame end")
    `MRC_ASSERT(a_state_cleared, (process && in_last_reg) |=> (count_reg == '0 && crc_reg == CRC_INIT), "frame state not cleared")

endmodule

/* tb/tb.sv */
// testbench for the modbus response checker: frame stimulus, crc predictor and result check
`timescale 1ns / 1ps

module tb;
    import mrc_pkg::*;

    localparam int FRAME_CAP   = 16;
    localparam int WORD_TARGET = 1100;
    localparam int CALM_TAIL   = 120;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [7:0] rid;
        bit         drain;
    } rx_word_t;

    typedef struct {
        status_t     st;
        logic [15:0] val;
        logic [7:0]  rid;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic [7:0]  register_index = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] reading;
    logic [7:0]  reg_echo;

    rx_word_t      pending_words[$];
    frame_result_t due_results[$];
    logic [7:0]    frm[$];

    // shadow frame state
    logic [15:0] sh_crc = CRC_INIT;
    logic [15:0] sh_tail = 16'h0000;
    logic [4:0]  sh_count = 5'd0;
    logic [15:0] sh_hold = 16'h0000;

    logic in_taken = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   mix_left = 0;
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   err_count = 0;
    int   n_words = 0;
    int   n_frames = 0;
    int   n_ok = 0;
    int   n_len = 0;
    int   n_crc = 0;
    int   n_long = 0;
    int   n_queued = 0;

    modbus_response_checker #(
        .MAX_FRAME_BYTES(FRAME_CAP)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .frame_end(frame_end),
        .register_index(register_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .reading(reading),
        .reg_echo(reg_echo)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // one byte through the reflected crc-16
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // advance the shadow frame state by one accepted word
    function automatic void absorb_byte(input logic [7:0] b, input logic last,
                                        input logic [7:0] rid);
        frame_result_t r;
        logic [15:0]   trailer_crc;
        logic [4:0]    pos;
        pos = sh_count;
        if (pos >= MIN_LENGTH)
            sh_crc = crc16_step(sh_crc, sh_tail[15:8]);
        sh_tail = {sh_tail[7:0], b};
        if (pos == READ_HI_IDX)
            sh_hold[15:8] = b;
        else if (pos == READ_LO_IDX)
            sh_hold[7:0] = b;
        if (sh_count < FRAME_CAP)
            sh_count = sh_count + 5'd1;
        if (last)
        begin
            // trailer carries the crc low byte first
            trailer_crc = {sh_tail[7:0], sh_tail[15:8]};
            r.st = STAT_OK;
            if (sh_count != GOOD_LENGTH)
                r.st = STAT_LEN;
            if (sh_count < MIN_LENGTH || sh_crc != trailer_crc)
                r.st = STAT_CRC;
            r.val = (r.st == STAT_OK) ? sh_hold : 16'h0000;
            r.rid = rid;
            if (sh_count == FRAME_CAP)
                n_long++;
            due_results.push_back(r);
            sh_crc = CRC_INIT;
            sh_tail = 16'h0000;
            sh_count = 5'd0;
            sh_hold = 16'h0000;
        end
    endfunction

    // append the crc of the bytes built so far, low byte first
    task automatic seal_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frm[i])
            c = crc16_step(c, frm[i]);
        frm.push_back(c[7:0]);
        frm.push_back(c[15:8]);
    endtask

    // move the built frame into the pending words
    task automatic queue_frame(input bit drain, input bit rid_rand, input logic [7:0] rid_val);
        rx_word_t w;
        foreach (frm[i])
        begin
            w.data = frm[i];
            w.last = (i == frm.size() - 1);
            w.rid = rid_rand ? 8'($urandom_range(255)) : rid_val;
            w.drain = drain && (i == 0);
            pending_words.push_back(w);
        end
        n_queued += frm.size();
        frm.delete();
    endtask

    // a well-formed read-input-register response body
    task automatic build_response(input logic [15:0] value);
        frm.push_back(8'($urandom_range(255)));
        frm.push_back(8'h04);
        frm.push_back(8'h02);
        frm.push_back(value[15:8]);
        frm.push_back(value[7:0]);
        seal_crc();
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus, reset and end of run
    initial
    begin
        int k;
        int n;
        int idx;
        // directed: extremes of the reading and register index
        build_response(16'hFFFF);
        queue_frame(1'b0, 1'b0, 8'hFF);
        build_response(16'h0000);
        queue_frame(1'b0, 1'b0, 8'h00);
        // one-byte frame: length and crc both wrong, crc wins
        frm.push_back(8'h5A);
        queue_frame(1'b0, 1'b1, 8'h00);
        // two-byte frame with an empty crc trailer: only the length is wrong
        frm.push_back(8'hFF);
        frm.push_back(8'hFF);
        queue_frame(1'b0, 1'b1, 8'h00);
        // two-byte frame with a bad trailer
        frm.push_back(8'h00);
        frm.push_back(8'h00);
        queue_frame(1'b0, 1'b1, 8'h00);
        // good length, corrupted payload, reading must read zero
        build_response(16'h1234);
        frm[3] = frm[3] ^ 8'h10;
        queue_frame(1'b0, 1'b1, 8'h00);

        // random frames, about half of them well formed
        while (n_queued < WORD_TARGET)
        begin
            k = $urandom_range(99);
            if (k < 50)
                build_response(pick_value());
            else if (k < 65)
            begin
                build_response(pick_value());
                idx = $urandom_range(frm.size() - 1);
                frm[idx] = frm[idx] ^ 8'($urandom_range(255, 1));
            end
            else if (k < 75)
            begin
                n = $urandom_range(12);
                repeat (n) frm.push_back(8'($urandom_range(255)));
                seal_crc();
            end
            else if (k < 83)
            begin
                n = $urandom_range(10, 1);
                repeat (n) frm.push_back(8'($urandom_range(255)));
            end
            else if (k < 88)
            begin
                n = $urandom_range(2, 1);
                repeat (n) frm.push_back($urandom_range(1) ? 8'hFF : 8'($urandom_range(255)));
            end
            else if (k < 94)
            begin
                // over-long frame, saturating the byte count
                n = ($urandom_range(7) == 0) ? 29 : $urandom_range(22, 15);
                repeat (n) frm.push_back(8'($urandom_range(255)));
                seal_crc();
            end
            else
            begin
                // response truncated or padded by one byte
                build_response(pick_value());
                if ($urandom_range(1))
                    void'(frm.pop_back());
                else
                    frm.push_back(8'($urandom_range(255)));
            end
            queue_frame((n_queued < 60) || ($urandom_range(99) < 3), 1'b1, 8'h00);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every word and every result
        do
        begin
            @(posedge clk);
            #1;
        end while (pending_words.size() != 0 || in_valid || due_results.size() != 0);
        repeat (12) @(posedge clk);
        #1;

        $display("tb summary: %0d words in, %0d frames out (ok %0d, length %0d, crc %0d)",
                 n_words, n_frames, n_ok, n_len, n_crc);
        $display("tb summary: %0d frames hit the byte count limit", n_long);
        foreach (due_results[i])
        begin
            $display("%0t: missing result: expected status %0d reading %h reg %h, got none",
                     $time, due_results[i].st, due_results[i].val, due_results[i].rid);
            err_count++;
        end
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("tb: errors");
        $finish;
    end

    // input driver and output stall, both on the falling edge
    always @(negedge clk)
    begin
        rx_word_t w;
        if (rst_n)
        begin
            // switch between quiet and busy stretches
            if (mix_left == 0)
            begin
                mix_left = $urandom_range(300, 30);
                case ($urandom_range(2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(2))
                    0: stall_pct = 0;
                    1: stall_pct = 15;
                    default: stall_pct = 50;
                endcase
            end
            else
                mix_left--;

            // next word once the current one is taken
            if (!in_valid || in_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_words[0].drain && due_results.size() != 0)
                    in_valid <= 1'b0;
                else if (pending_words.size() > CALM_TAIL && $urandom_range(99) < gap_pct)
                begin
                    gap_left = $urandom_range(5);
                    in_valid <= 1'b0;
                end
                else
                begin
                    w = pending_words.pop_front();
                    rx_byte <= w.data;
                    frame_end <= w.last;
                    register_index <= w.rid;
                    in_valid <= 1'b1;
                end
            end

            // receiver stall bursts
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (pending_words.size() > CALM_TAIL && $urandom_range(99) < stall_pct)
            begin
                stall_left = $urandom_range(5);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // accepted words feed the predictor, accepted results are checked
    always @(posedge clk)
    begin
        frame_result_t e;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                n_words++;
                absorb_byte(rx_byte, frame_end, register_index);
            end
            if (out_valid && !out_stall)
            begin
                n_frames++;
                case (status)
                    STAT_OK: n_ok++;
                    STAT_LEN: n_len++;
                    default: n_crc++;
                endcase
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got status %0d reading %h reg %h",
                             $time, status, reading, reg_echo);
                    err_count++;
                end
                else
                begin
                    e = due_results.pop_front();
                    if (status !== e.st)
                    begin
                        $display("%0t: status: expected %0d, got %0d", $time, e.st, status);
                        err_count++;
                    end
                    if (reading !== e.val)
                    begin
                        $display("%0t: reading: expected %h, got %h", $time, e.val, reading);
                        err_count++;
                    end
                    if (reg_echo !== e.rid)
                    begin
                        $display("%0t: reg_echo: expected %h, got %h", $time, e.rid, reg_echo);
                        err_count++;
                    end
                end
            end
        end
    end

endmodule
